// ===== src/urd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the unique random draw pool.
package urd_pkg;

    localparam int VW        = 11;   // value, range and count width
    localparam int WORD_W    = 32;   // random word width
    localparam int STEP_W    = 5;    // modulo step counter width
    localparam int CFG_IDX_W = 4;

    typedef logic [VW-1:0]        t_value;
    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(WORD_W - 1);

    localparam t_cfg_idx REG_POOL_RANGE = 4'd0;
    localparam t_cfg_idx REG_DRAW_COUNT = 4'd1;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_WORD  = 1'b1;

    localparam t_value RANGE_RST = 11'd1024;
    localparam t_value COUNT_RST = 11'd1024;

endpackage

// ===== src/urd_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces: item input, result output and register write.
interface urd_in_if;
    import urd_pkg::*;
    logic  valid;
    logic  ready;
    logic  action;
    t_word random_word;
    modport source (output valid, output action, output random_word, input ready);
    modport sink   (input valid, input action, input random_word, output ready);
endinterface

interface urd_out_if;
    import urd_pkg::*;
    logic   valid;
    logic   ready;
    t_value drawn_value;
    logic   last;
    modport source (output valid, output drawn_value, output last, input ready);
    modport sink   (input valid, input drawn_value, input last, output ready);
endinterface

interface urd_cfg_if;
    import urd_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_value   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/urd_mod.sv =====
`timescale 1ns / 1ps
// Iterative modulo of a 32-bit word by the pool size, one bit per cycle.
module urd_mod (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  urd_pkg::t_word  i_dividend,
    input  urd_pkg::t_value i_divisor,
    output logic           o_done,
    output urd_pkg::t_value o_rem
);
    import urd_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    t_word             r_dvd;
    t_value            r_div;
    t_value            r_rem;
    t_value            n_rem;
    logic [VW:0]       shifted;

    // remainder stays below the divisor, so one compare and subtract per bit
    always_comb begin
        shifted = {r_rem, r_dvd[WORD_W-1]};
        if (shifted >= {1'b0, r_div}) begin
            n_rem = VW'(shifted - {1'b0, r_div});
        end else begin
            n_rem = VW'(shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == STEP_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== src/unique_random_draw_pool_unit.sv =====
`timescale 1ns / 1ps
// Random draw without replacement: top level with pool memory and sequencer.
// Word: after accept, 32 modulo steps, done, memory read, then mark write-back and result;
//   the check waits while the output register is full; a batch end adds a compaction pass.
// Start: fills the pool, one pool entry written per cycle.
// One item at a time; a result waits in an output register while the next item runs.
// Reset (synchronous, active low): idle, pool empty, registers 1024/1024.
module unique_random_draw_pool_unit #(
    parameter int MAX_RANGE = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    urd_in_if.sink    i_in,
    urd_out_if.source o_out,
    urd_cfg_if.sink   i_cfg
);
    import urd_pkg::*;

    localparam int AW    = $clog2(MAX_RANGE);
    localparam int DEPTH = 2 * (1 << AW);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_FILL    = 3'd1;
    localparam logic [2:0] S_DIV     = 3'd2;
    localparam logic [2:0] S_READ    = 3'd3;
    localparam logic [2:0] S_CHECK   = 3'd4;
    localparam logic [2:0] S_COMPACT = 3'd5;

    // entry: taken mark on top, value below; address MSB selects the bank
    logic [VW:0] mem [DEPTH];
    logic [VW:0] r_rdata;
    logic [AW:0] rd_addr;
    logic [AW:0] wr_addr;
    logic [VW:0] wr_data;
    logic        wr_en;

    logic [2:0] r_state;
    t_value     r_pool_range;
    t_value     r_draw_count;
    t_value     r_range;
    t_value     r_count;
    logic       r_bank;
    t_value     r_size;
    t_value     r_batch;
    t_value     r_emitted;
    logic       r_running;
    t_value     r_idx;
    t_value     r_kept;
    logic       r_cv;
    t_value     r_slot;
    logic       r_out_valid;
    t_value     r_out_value;
    logic       r_out_last;

    logic   in_acc;
    logic   cfg_acc;
    logic   word_go;
    t_value range_eff;
    t_value count_eff;
    logic   div_done;
    t_value div_rem;
    logic   taken;
    t_value rd_val;
    logic   can_out;
    logic   chk_fire;
    logic   produced;
    t_value emitted_nx;
    t_value batch_nx;
    logic   hit_last;
    logic   do_compact;
    logic   cmp_issue;
    logic   cmp_done;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign word_go     = in_acc && (i_in.action == ACT_WORD) && r_running && (r_size != '0);

    assign range_eff = ({21'd0, r_pool_range} > 32'(MAX_RANGE)) ? VW'(MAX_RANGE) : r_pool_range;
    assign count_eff = (r_draw_count > range_eff) ? range_eff : r_draw_count;

    urd_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (word_go),
        .i_dividend (i_in.random_word),
        .i_divisor  (r_size),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign taken      = r_rdata[VW];
    assign rd_val     = r_rdata[VW-1:0];
    assign can_out    = !r_out_valid || o_out.ready;
    assign chk_fire   = (r_state == S_CHECK) && (taken || can_out);
    assign produced   = chk_fire && !taken;
    assign emitted_nx = r_emitted + VW'(produced);
    assign batch_nx   = r_batch + VW'(1);
    assign hit_last   = produced && (emitted_nx >= r_count);
    assign do_compact = (batch_nx >= r_count) || (emitted_nx >= r_count);
    assign cmp_issue  = (r_state == S_COMPACT) && (r_idx < r_size);
    assign cmp_done   = (r_state == S_COMPACT) && !cmp_issue && !r_cv;

    always_comb begin
        rd_addr = {r_bank, AW'(r_slot)};
        wr_en   = 1'b0;
        wr_addr = {r_bank, AW'(r_slot)};
        wr_data = {1'b1, rd_val};
        if (r_state == S_COMPACT) begin
            rd_addr = {r_bank, AW'(r_idx)};
        end
        if (r_state == S_FILL) begin
            wr_en   = 1'b1;
            wr_addr = {1'b0, AW'(r_idx)};
            wr_data = {1'b0, r_idx + VW'(1)};
        end else if (produced) begin
            wr_en = 1'b1;
        end else if (r_state == S_COMPACT && r_cv && !taken) begin
            // untaken entries move in order to the other bank
            wr_en   = 1'b1;
            wr_addr = {~r_bank, AW'(r_kept)};
            wr_data = {1'b0, rd_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pool_range <= RANGE_RST;
            r_draw_count <= COUNT_RST;
            r_range      <= '0;
            r_count      <= '0;
            r_bank       <= 1'b0;
            r_size       <= '0;
            r_batch      <= '0;
            r_emitted    <= '0;
            r_running    <= 1'b0;
            r_idx        <= '0;
            r_kept       <= '0;
            r_cv         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_acc) begin
                unique case (i_cfg.index)
                    REG_POOL_RANGE: r_pool_range <= i_cfg.data;
                    REG_DRAW_COUNT: r_draw_count <= i_cfg.data;
                    default: ;
                endcase
            end

            if (produced) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in.action == ACT_START) begin
                        r_range   <= range_eff;
                        r_count   <= count_eff;
                        r_bank    <= 1'b0;
                        r_size    <= range_eff;
                        r_batch   <= '0;
                        r_emitted <= '0;
                        r_running <= (count_eff != '0);
                        r_idx     <= '0;
                        if (count_eff != '0) begin
                            r_state <= S_FILL;
                        end
                    end else if (word_go) begin
                        r_state <= S_DIV;
                    end else if (in_acc) begin
                        r_running <= 1'b0;
                    end
                end
                S_FILL: begin
                    r_idx <= r_idx + VW'(1);
                    if (r_idx == r_range - VW'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (chk_fire) begin
                        r_emitted <= emitted_nx;
                        r_batch   <= batch_nx;
                        if (hit_last) begin
                            r_running <= 1'b0;
                        end
                        if (do_compact) begin
                            r_idx   <= '0;
                            r_kept  <= '0;
                            r_cv    <= 1'b0;
                            r_state <= S_COMPACT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_COMPACT: begin
                    r_cv <= cmp_issue;
                    if (cmp_issue) begin
                        r_idx <= r_idx + VW'(1);
                    end
                    if (r_cv && !taken) begin
                        r_kept <= r_kept + VW'(1);
                    end
                    if (cmp_done) begin
                        r_size  <= r_kept;
                        r_bank  <= ~r_bank;
                        r_batch <= '0;
                        if (r_kept == '0) begin
                            r_running <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && div_done) begin
            r_slot <= div_rem;
        end
        if (produced) begin
            r_out_value <= rd_val;
            r_out_last  <= hit_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.drawn_value = r_out_value;
    assign o_out.last        = r_out_last;

endmodule

// ===== src/urd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the draw pool, bound to the top level.
module urd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_in_action,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input urd_pkg::t_value i_out_value,
    input logic           i_out_last
);
    import urd_pkg::*;

    logic r_after_last;
    logic r_start_since;
    logic start_acc;
    logic out_acc;

    assign start_acc = i_in_valid && i_in_ready && (i_in_action == ACT_START);
    assign out_acc   = i_out_valid && i_out_ready;

    // set once the final word of a sequence has gone out, cleared by a start;
    // a final word taken after a start that followed the previous output word
    // may belong to the abandoned sequence, so it does not arm the check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_last  <= 1'b0;
            r_start_since <= 1'b0;
        end else begin
            if (start_acc) begin
                r_after_last <= 1'b0;
            end else if (out_acc && i_out_last && !r_start_since) begin
                r_after_last <= 1'b1;
            end
            if (start_acc) begin
                r_start_since <= 1'b1;
            end else if (out_acc) begin
                r_start_since <= 1'b0;
            end
        end
    end

    a_value_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_value != '0))
        else $error("drawn value of zero");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_value) && $stable(i_out_last)))
        else $error("stalled result changed");

    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_after_last |-> !i_out_valid)
        else $error("result after the final word without a start");

    a_rose_not_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_valid && i_in_ready))
        else $error("result appeared right after an input accept");

endmodule

bind unique_random_draw_pool_unit urd_checker u_urd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_action (i_in.action),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.drawn_value),
    .i_out_last  (o_out.last)
);
